>>> rtl/tbrl_pkg.sv
// Token bucket rate limiter: shared types and constants.
// No dependencies; used by every other file of the block.
package tbrl_pkg;

   localparam int TIME_W   = 64;
   localparam int RATE_W   = 30;
   localparam int BURST_W  = 16;
   localparam int COUNT_W  = 16;
   localparam int STATUS_W = 2;
   localparam int ACTION_W = 2;
   localparam int DIV_CNT_W = 6;

   localparam logic [TIME_W-1:0]    NS_PER_SECOND  = 64'd1000000000;
   localparam logic [RATE_W-1:0]    RATE_RESET     = 30'd1000;
   localparam logic [BURST_W-1:0]   BURST_RESET    = 16'd16;
   localparam logic [RATE_W-1:0]    INTERVAL_RESET = 30'd1000000;
   localparam logic [DIV_CNT_W-1:0] DIV_LAST       = 6'd63;

   localparam logic CSR_RATE  = 1'b0;
   localparam logic CSR_BURST = 1'b1;

   localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_ONE   = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_MANY  = 2'd2;

   localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_WAIT   = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_EXCEED = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INTERVAL,
      ST_CHECK,
      ST_DIVIDE,
      ST_ACT
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

>>> rtl/tbrl_if.sv
// Token bucket rate limiter: request and response channel interfaces.
// Depends on tbrl_pkg for field widths.
interface tbrl_req_if;
   logic                          valid;
   logic                          ready;
   logic [tbrl_pkg::ACTION_W-1:0] action;
   logic [tbrl_pkg::TIME_W-1:0]   now_ns;
   logic [tbrl_pkg::BURST_W-1:0]  request_count;

   modport source (output valid, output action, output now_ns, output request_count,
                   input ready);
   modport sink   (input valid, input action, input now_ns, input request_count,
                   output ready);
endinterface

interface tbrl_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [tbrl_pkg::STATUS_W-1:0] status;
   logic [tbrl_pkg::COUNT_W-1:0]  tokens_left;

   modport source (output valid, output status, output tokens_left, input ready);
   modport sink   (input valid, input status, input tokens_left, output ready);
endinterface

>>> rtl/tbrl_divider.sv
// Token bucket rate limiter: shared restoring divider, one quotient bit per cycle.
// 64-bit dividend by 30-bit divisor. Depends on tbrl_pkg.
module tbrl_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [tbrl_pkg::TIME_W-1:0]   dividend,
   input  logic [tbrl_pkg::RATE_W-1:0]   divisor,
   output tbrl_pkg::div_status_type      status,
   output logic [tbrl_pkg::TIME_W-1:0]   quotient
);

   logic [tbrl_pkg::TIME_W-1:0]    quo_ff, quo_in;
   logic [tbrl_pkg::RATE_W-1:0]    rem_ff, rem_in;
   logic [tbrl_pkg::RATE_W-1:0]    dsr_ff, dsr_in;
   logic [tbrl_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;

   logic [tbrl_pkg::RATE_W:0]   shifted;
   logic [tbrl_pkg::RATE_W+1:0] diff;
   logic                        fits;

   assign shifted = {rem_ff, quo_ff[tbrl_pkg::TIME_W-1]};
   assign diff    = {1'b0, shifted} - {2'b00, dsr_ff};
   assign fits    = ~diff[tbrl_pkg::RATE_W+1];

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[tbrl_pkg::RATE_W-1:0] : shifted[tbrl_pkg::RATE_W-1:0];
         quo_in = {quo_ff[tbrl_pkg::TIME_W-2:0], fits};
         cnt_in = cnt_ff + tbrl_pkg::DIV_CNT_W'(1);
         if (cnt_ff == tbrl_pkg::DIV_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule

>>> rtl/token_bucket_rate_limiter_unit.sv
// Token bucket rate limiter, top level: sequencer, bucket state and CSRs.
// Depends on tbrl_pkg, tbrl_if and tbrl_divider.
//
// Usage: each request on req_bus carries an action, a nanosecond timestamp
// and a token count; one response per request leaves on rsp_bus with a status
// and the tokens left. The bucket is refilled from the elapsed time first,
// which needs elapsed / interval in the shared bit-serial divider.
// Each request is registered, checked for a refill (ST_CHECK), divided in
// ST_DIVIDE if one is due, and written to the response register in ST_ACT;
// one request at a time. A write of tokens_per_second recomputes the interval
// as 1e9 / rate in the same divider (0 for a rate of 0), and req_bus is not
// ready meanwhile. A write of burst_limit reloads the token count at once.
// req_bus is also held off in any cycle with a CSR write.
// Reset: rate 1000, burst 16, interval 1000000 ns, 16 tokens, last refill 0.
// The response is held in an output register; while the receiver stalls the
// next request may be taken and worked on, and waits for that register.
module token_bucket_rate_limiter_unit #(
   parameter int TOKEN_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   tbrl_req_if.sink                      req_bus,
   tbrl_rsp_if.source                    rsp_bus,
   input  logic                          csr_write_enable,
   input  logic                          csr_index,
   input  logic [tbrl_pkg::RATE_W-1:0]   csr_write_data
);

   localparam int CW = (TOKEN_WIDTH > tbrl_pkg::BURST_W) ? TOKEN_WIDTH : tbrl_pkg::BURST_W;
   localparam logic [CW-1:0] TOKEN_MAX_W = CW'({TOKEN_WIDTH{1'b1}});

   tbrl_pkg::state_type state_ff, state_in;

   logic [tbrl_pkg::RATE_W-1:0]   rate_ff, rate_in;
   logic [tbrl_pkg::BURST_W-1:0]  burst_ff, burst_in;
   logic [tbrl_pkg::RATE_W-1:0]   interval_ff, interval_in;
   logic [TOKEN_WIDTH-1:0]        count_ff, count_in;
   logic [tbrl_pkg::TIME_W-1:0]   last_ff, last_in;
   logic [tbrl_pkg::TIME_W-1:0]   now_ff, now_in;
   logic [tbrl_pkg::TIME_W-1:0]   elapsed_ff, elapsed_in;
   logic [tbrl_pkg::ACTION_W-1:0] action_ff, action_in;
   logic [tbrl_pkg::BURST_W-1:0]  want_ff, want_in;
   logic                          pend_ff, pend_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [tbrl_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [tbrl_pkg::COUNT_W-1:0]  rsp_tokens_ff, rsp_tokens_in;

   logic                          div_start;
   logic [tbrl_pkg::TIME_W-1:0]   div_dividend;
   logic [tbrl_pkg::RATE_W-1:0]   div_divisor;
   tbrl_pkg::div_status_type      div_status;
   logic [tbrl_pkg::TIME_W-1:0]   div_quotient;

   logic                   req_accept;
   logic                   rsp_free;
   logic                   refill_due;
   logic [CW-1:0]          burst_w;
   logic [CW-1:0]          csr_burst_w;
   logic [TOKEN_WIDTH-1:0] cap;
   logic [TOKEN_WIDTH-1:0] csr_cap;
   logic [TOKEN_WIDTH:0]   refill_sum;
   logic [TOKEN_WIDTH-1:0] refilled;
   logic [CW-1:0]          count_w;
   logic [CW-1:0]          want_w;
   logic [TOKEN_WIDTH-1:0] act_count;
   logic [tbrl_pkg::STATUS_W-1:0] act_status;
   logic [CW-1:0]          act_count_w;

   tbrl_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .status   (div_status),
      .quotient (div_quotient)
   );

   assign req_bus.ready = (state_ff == tbrl_pkg::ST_IDLE) && !pend_ff && !csr_write_enable;
   assign req_accept    = req_bus.valid && req_bus.ready;
   assign rsp_free      = !rsp_valid_ff || rsp_bus.ready;

   assign burst_w     = CW'(burst_ff);
   assign csr_burst_w = CW'(csr_write_data[tbrl_pkg::BURST_W-1:0]);
   assign cap     = TOKEN_WIDTH'((burst_w > TOKEN_MAX_W) ? TOKEN_MAX_W : burst_w);
   assign csr_cap = TOKEN_WIDTH'((csr_burst_w > TOKEN_MAX_W) ? TOKEN_MAX_W : csr_burst_w);

   assign refill_due = (interval_ff != '0) &&
                       (elapsed_ff >= tbrl_pkg::TIME_W'(interval_ff));

   // quotient is only summed when it does not exceed the cap
   assign refill_sum = (TOKEN_WIDTH+1)'(count_ff) +
                       (TOKEN_WIDTH+1)'(div_quotient[TOKEN_WIDTH-1:0]);
   always_comb begin
      if (div_quotient > tbrl_pkg::TIME_W'(cap)) begin
         refilled = cap;
      end else if (refill_sum > (TOKEN_WIDTH+1)'(cap)) begin
         refilled = cap;
      end else begin
         refilled = refill_sum[TOKEN_WIDTH-1:0];
      end
   end

   assign count_w = CW'(count_ff);
   assign want_w  = CW'(want_ff);
   always_comb begin
      act_count  = count_ff;
      act_status = tbrl_pkg::STAT_OK;
      case (action_ff)
         tbrl_pkg::ACT_ONE: begin
            if (count_ff != '0) begin
               act_count = count_ff - TOKEN_WIDTH'(1);
            end else begin
               act_status = tbrl_pkg::STAT_WAIT;
            end
         end
         tbrl_pkg::ACT_MANY: begin
            if (want_ff > burst_ff) begin
               act_status = tbrl_pkg::STAT_EXCEED;
            end else if (count_w >= want_w) begin
               act_count = TOKEN_WIDTH'(count_w - want_w);
            end else begin
               act_status = tbrl_pkg::STAT_WAIT;
            end
         end
         default: begin
            act_count  = count_ff;
            act_status = tbrl_pkg::STAT_OK;
         end
      endcase
   end
   assign act_count_w = CW'(act_count);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tbrl_pkg::ST_IDLE: begin
            if (pend_ff && !csr_write_enable && rate_ff != '0) begin
               state_in = tbrl_pkg::ST_INTERVAL;
            end else if (req_accept) begin
               state_in = tbrl_pkg::ST_CHECK;
            end
         end
         tbrl_pkg::ST_INTERVAL: begin
            if (div_status.done) begin
               state_in = tbrl_pkg::ST_IDLE;
            end
         end
         tbrl_pkg::ST_CHECK: begin
            state_in = refill_due ? tbrl_pkg::ST_DIVIDE : tbrl_pkg::ST_ACT;
         end
         tbrl_pkg::ST_DIVIDE: begin
            if (div_status.done) begin
               state_in = tbrl_pkg::ST_ACT;
            end
         end
         tbrl_pkg::ST_ACT: begin
            if (rsp_free) begin
               state_in = tbrl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tbrl_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      rate_in       = rate_ff;
      burst_in      = burst_ff;
      interval_in   = interval_ff;
      count_in      = count_ff;
      last_in       = last_ff;
      now_in        = now_ff;
      elapsed_in    = elapsed_ff;
      action_in     = action_ff;
      want_in       = want_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in = rsp_status_ff;
      rsp_tokens_in = rsp_tokens_ff;
      div_start     = 1'b0;
      div_dividend  = elapsed_ff;
      div_divisor   = interval_ff;

      case (state_ff)
         tbrl_pkg::ST_IDLE: begin
            if (pend_ff && !csr_write_enable) begin
               pend_in = 1'b0;
               if (rate_ff == '0) begin
                  interval_in = '0;
               end else begin
                  div_start    = 1'b1;
                  div_dividend = tbrl_pkg::NS_PER_SECOND;
                  div_divisor  = rate_ff;
               end
            end else if (req_accept) begin
               action_in  = req_bus.action;
               now_in     = req_bus.now_ns;
               want_in    = req_bus.request_count;
               elapsed_in = req_bus.now_ns - last_ff;
            end
         end
         tbrl_pkg::ST_INTERVAL: begin
            if (div_status.done) begin
               interval_in = div_quotient[tbrl_pkg::RATE_W-1:0];
            end
         end
         tbrl_pkg::ST_CHECK: begin
            div_start = refill_due;
         end
         tbrl_pkg::ST_DIVIDE: begin
            if (div_status.done) begin
               count_in = refilled;
               last_in  = now_ff;
            end
         end
         tbrl_pkg::ST_ACT: begin
            if (rsp_free) begin
               count_in      = act_count;
               rsp_valid_in  = 1'b1;
               rsp_status_in = act_status;
               rsp_tokens_in = act_count_w[tbrl_pkg::COUNT_W-1:0];
            end
         end
         default: begin
            pend_in = pend_ff;
         end
      endcase

      if (csr_write_enable) begin
         case (csr_index)
            tbrl_pkg::CSR_RATE: begin
               rate_in = csr_write_data;
               pend_in = 1'b1;
            end
            tbrl_pkg::CSR_BURST: begin
               burst_in = csr_write_data[tbrl_pkg::BURST_W-1:0];
               count_in = csr_cap;
            end
            default: begin
               pend_in = pend_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      now_ff        <= now_in;
      elapsed_ff    <= elapsed_in;
      action_ff     <= action_in;
      want_ff       <= want_in;
      rsp_status_ff <= rsp_status_in;
      rsp_tokens_ff <= rsp_tokens_in;
      if (reset) begin
         state_ff     <= tbrl_pkg::ST_IDLE;
         rate_ff      <= tbrl_pkg::RATE_RESET;
         burst_ff     <= tbrl_pkg::BURST_RESET;
         interval_ff  <= tbrl_pkg::INTERVAL_RESET;
         count_ff     <= TOKEN_WIDTH'(tbrl_pkg::BURST_RESET);
         last_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rate_ff      <= rate_in;
         burst_ff     <= burst_in;
         interval_ff  <= interval_in;
         count_ff     <= count_in;
         last_ff      <= last_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = rsp_status_ff;
   assign rsp_bus.tokens_left = rsp_tokens_ff;

endmodule

>>> test/tbrl_checker.sv
`timescale 1ns / 100ps
// Checker for the token bucket rate limiter: watches the request, response
// and CSR ports, predicts each response and compares it field by field.
// Depends on tbrl_pkg and the channel interfaces in tbrl_if.
module tbrl_checker (
   input  logic                        clock,
   input  logic                        reset,
   tbrl_req_if                         req_mon,
   tbrl_rsp_if                         rsp_mon,
   input  logic                        csr_write_enable,
   input  logic                        csr_index,
   input  logic [tbrl_pkg::RATE_W-1:0] csr_write_data,
   output int                          mismatches,
   output int                          outstanding
);

   typedef struct packed {
      logic [tbrl_pkg::STATUS_W-1:0] status;
      logic [tbrl_pkg::COUNT_W-1:0]  tokens_left;
   } outcome_type;

   outcome_type                  outcome_q[$];
   logic [tbrl_pkg::BURST_W-1:0] burst;
   logic [tbrl_pkg::COUNT_W-1:0] tokens;
   logic [tbrl_pkg::TIME_W-1:0]  refill_stamp;
   logic [tbrl_pkg::TIME_W-1:0]  interval;
   int                           errors  = 0;
   int                           pending = 0;

   assign mismatches  = errors;
   assign outstanding = pending;

   function automatic logic [tbrl_pkg::TIME_W-1:0] interval_of(
      logic [tbrl_pkg::RATE_W-1:0] rate);
      return (rate == '0) ? '0 : tbrl_pkg::NS_PER_SECOND / rate;
   endfunction

   // refill from elapsed time, then apply the request to the bucket
   function automatic outcome_type serve_request(logic [tbrl_pkg::ACTION_W-1:0] action,
                                                 logic [tbrl_pkg::TIME_W-1:0]   now,
                                                 logic [tbrl_pkg::BURST_W-1:0]  want);
      logic [tbrl_pkg::TIME_W-1:0] elapsed;
      logic [tbrl_pkg::TIME_W-1:0] added;
      logic [tbrl_pkg::TIME_W-1:0] next;
      outcome_type                 result;
      elapsed = now - refill_stamp;
      if (interval != '0 && elapsed >= interval) begin
         added        = elapsed / interval;
         refill_stamp = now;
         next         = (added > burst) ? tbrl_pkg::TIME_W'(burst) : tokens + added;
         tokens       = (next > burst) ? burst : next[tbrl_pkg::COUNT_W-1:0];
      end
      result.status = tbrl_pkg::STAT_OK;
      if (action == tbrl_pkg::ACT_ONE) begin
         if (tokens != '0) tokens = tokens - tbrl_pkg::COUNT_W'(1);
         else result.status = tbrl_pkg::STAT_WAIT;
      end else if (action == tbrl_pkg::ACT_MANY) begin
         if (want > burst) result.status = tbrl_pkg::STAT_EXCEED;
         else if (tokens >= want) tokens = tokens - want;
         else result.status = tbrl_pkg::STAT_WAIT;
      end
      result.tokens_left = tokens;
      return result;
   endfunction

   function automatic void report(string what, outcome_type exp, outcome_type got);
      errors++;
      if (errors <= 10)
         $display("%0t %0s: expected status %0d tokens %0d, got status %0d tokens %0d",
                  $time, what, exp.status, exp.tokens_left, got.status, got.tokens_left);
   endfunction

   always @(posedge clock) begin
      outcome_type got;
      outcome_type exp;
      if (reset) begin
         burst        = tbrl_pkg::BURST_RESET;
         tokens       = tbrl_pkg::BURST_RESET;
         interval     = interval_of(tbrl_pkg::RATE_RESET);
         refill_stamp = '0;
         outcome_q.delete();
      end else begin
         if (csr_write_enable) begin
            if (csr_index == tbrl_pkg::CSR_RATE) begin
               interval = interval_of(csr_write_data);
            end else begin
               burst  = csr_write_data[tbrl_pkg::BURST_W-1:0];
               tokens = burst;
            end
         end
         if (req_mon.valid && req_mon.ready)
            outcome_q.push_back(serve_request(req_mon.action, req_mon.now_ns,
                                              req_mon.request_count));
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.status      = rsp_mon.status;
            got.tokens_left = rsp_mon.tokens_left;
            if (outcome_q.size() == 0) begin
               report("response with no request", '0, got);
            end else begin
               exp = outcome_q.pop_front();
               if (got.status != exp.status || got.tokens_left != exp.tokens_left)
                  report("response mismatch", exp, got);
            end
         end
      end
      pending = outcome_q.size();
   end

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps
// Testbench top for token_bucket_rate_limiter_unit: clock, reset, request
// stimulus, CSR settings and response back-pressure; verdict from tbrl_checker.
// Depends on tbrl_pkg, tbrl_if, the block and tbrl_checker.
module tb;

   localparam logic [tbrl_pkg::ACTION_W-1:0] ACT_SPARE   = 2'd3;
   localparam logic [tbrl_pkg::RATE_W-1:0]   RATE_TOP    = 30'h3FFF_FFFF;
   localparam logic [tbrl_pkg::RATE_W-1:0]   RATE_GIGA   = 30'd1000000000;
   localparam int                            CYCLE_LIMIT = 1500000;
   localparam int                            DRAIN_WAIT  = 80;
   localparam int                            HOLD_CYCLES = 300;
   localparam int                            PHASES      = 12;
   localparam int                            PHASE_ITEMS = 157;
   localparam int                            FIXED       = 6;

   typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_type;

   localparam logic [tbrl_pkg::RATE_W-1:0]  RATE_PLAN [FIXED] =
      '{30'd1000, RATE_GIGA, 30'd1, 30'd0, RATE_TOP, 30'd1000000};
   localparam logic [tbrl_pkg::BURST_W-1:0] BURST_PLAN [FIXED] =
      '{16'd16, 16'hFFFF, 16'd0, 16'd100, 16'd7, 16'd1};

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         csr_write_enable;
   logic                         csr_index;
   logic [tbrl_pkg::RATE_W-1:0]  csr_write_data;
   int                           mismatches;
   int                           outstanding;
   int                           send_idle_pct  = 0;
   int                           recv_stall_pct = 0;
   int                           hold_seq       = 0;
   int                           hold_seen      = 0;
   int                           hold_left      = 0;
   int                           cycles         = 0;
   logic [tbrl_pkg::TIME_W-1:0]  stamp;
   logic [tbrl_pkg::TIME_W-1:0]  interval;
   logic [tbrl_pkg::BURST_W-1:0] burst;

   tbrl_req_if req_bus();
   tbrl_rsp_if rsp_bus();

   token_bucket_rate_limiter_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   tbrl_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_bus),
      .rsp_mon          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .mismatches       (mismatches),
      .outstanding      (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // response back-pressure; a new hold_seq starts a long hold-off
   always @(posedge clock) begin
      if (hold_seq != hold_seen) begin
         hold_seen     <= hold_seq;
         hold_left     <= HOLD_CYCLES;
         rsp_bus.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left     <= hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic settle();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_csr(logic idx, logic [tbrl_pkg::RATE_W-1:0] data);
      settle();
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_request(logic [tbrl_pkg::ACTION_W-1:0] act,
                               logic [tbrl_pkg::TIME_W-1:0]   now,
                               logic [tbrl_pkg::BURST_W-1:0]  want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.action        <= act;
      req_bus.now_ns        <= now;
      req_bus.request_count <= want;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic random_request();
      logic [tbrl_pkg::ACTION_W-1:0] act;
      logic [tbrl_pkg::BURST_W-1:0]  want;
      logic [tbrl_pkg::TIME_W-1:0]   step;
      int                            pick;
      int                            top;
      step = (interval != '0) ? interval : 64'd1000000;
      pick = $urandom_range(99);
      if (pick < 55)
         stamp = stamp + (step * $urandom_range(0, 300)) / 100 + $urandom_range(0, 3);
      else if (pick < 67)
         stamp = stamp + ({$urandom, $urandom} >> $urandom_range(0, 63));
      else if (pick < 79)
         stamp = stamp - $urandom_range(1, 1000000);
      else if (pick < 85)
         stamp = {$urandom, $urandom};
      pick = $urandom_range(99);
      if (pick < 10) act = tbrl_pkg::ACT_QUERY;
      else if (pick < 15) act = ACT_SPARE;
      else if (pick < 55) act = tbrl_pkg::ACT_ONE;
      else act = tbrl_pkg::ACT_MANY;
      pick = $urandom_range(99);
      top  = (burst == 16'hFFFF) ? 65535 : burst + 1;
      if (pick < 50) want = tbrl_pkg::BURST_W'($urandom_range(0, 4));
      else if (pick < 80) want = tbrl_pkg::BURST_W'($urandom_range(0, top));
      else want = tbrl_pkg::BURST_W'($urandom_range(0, 65535));
      send_request(act, stamp, want);
   endtask

   initial begin
      logic [tbrl_pkg::RATE_W-1:0] rate;
      idle_mode_type               mode;
      reset                 = 1'b1;
      csr_write_enable      = 1'b0;
      csr_index             = tbrl_pkg::CSR_RATE;
      csr_write_data        = '0;
      req_bus.valid         = 1'b0;
      req_bus.action        = tbrl_pkg::ACT_QUERY;
      req_bus.now_ns        = '0;
      req_bus.request_count = '0;
      interval              = tbrl_pkg::INTERVAL_RESET;
      burst                 = tbrl_pkg::BURST_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset settings: 16 tokens, one token per ms
      send_request(tbrl_pkg::ACT_QUERY, 64'd0, 16'd0);
      send_request(ACT_SPARE, 64'd0, 16'hFFFF);
      send_request(tbrl_pkg::ACT_MANY, 64'd0, 16'd0);
      send_request(tbrl_pkg::ACT_MANY, 64'd0, 16'd17);
      send_request(tbrl_pkg::ACT_MANY, 64'd0, 16'd16);
      send_request(tbrl_pkg::ACT_ONE, 64'd0, 16'd0);
      send_request(tbrl_pkg::ACT_MANY, 64'd0, 16'd5);
      send_request(tbrl_pkg::ACT_MANY, 64'd0, 16'hFFFF);
      send_request(tbrl_pkg::ACT_ONE, 64'd3000000, 16'd0);
      send_request(tbrl_pkg::ACT_MANY, 64'd3999999, 16'd10);
      // time going backwards refills to the limit
      send_request(tbrl_pkg::ACT_MANY, 64'd1000000, 16'd10);
      send_request(tbrl_pkg::ACT_QUERY, 64'hFFFF_FFFF_FFFF_FFFF, 16'd0);
      send_request(tbrl_pkg::ACT_ONE, 64'd0, 16'd0);
      send_request(tbrl_pkg::ACT_ONE, 64'hAAAA_AAAA_AAAA_AAAA, 16'h5555);
      send_request(tbrl_pkg::ACT_ONE, 64'h5555_5555_5555_5555, 16'hAAAA);
      stamp = 64'h5555_5555_5555_5555;

      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph < FIXED) begin
            rate  = RATE_PLAN[ph];
            burst = BURST_PLAN[ph];
         end else begin
            rate  = tbrl_pkg::RATE_W'($urandom) >> $urandom_range(0, 29);
            burst = tbrl_pkg::BURST_W'($urandom) >> $urandom_range(0, 15);
         end
         interval = (rate == '0) ? '0 : tbrl_pkg::NS_PER_SECOND / rate;
         write_csr(tbrl_pkg::CSR_RATE, rate);
         write_csr(tbrl_pkg::CSR_BURST, {14'($urandom), burst});
         mode = idle_mode_type'(ph % 4);
         case (mode)
            IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SEND: begin send_idle_pct = 61; recv_stall_pct = 0;  end
            IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 61; end
            default:   begin send_idle_pct = 28; recv_stall_pct = 28; end
         endcase
         if (ph == 4) hold_seq <= hold_seq + 1;
         for (int i = 0; i < PHASE_ITEMS; i++) random_request();
      end

      settle();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
